### design/msb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msb_pkg;
	localparam int SCREEN_WIDTH = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int SCREEN_PAGES = SCREEN_HEIGHT / 8;
	localparam int FB_BYTES = SCREEN_WIDTH * SCREEN_PAGES;
	localparam int AW = 10;

	localparam logic [1:0] KIND_SPRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] REG_X = 3'd0;
	localparam logic [2:0] REG_Y = 3'd1;
	localparam logic [2:0] REG_W = 3'd2;
	localparam logic [2:0] REG_H = 3'd3;
	localparam logic [2:0] REG_MIRROR = 3'd4;
	localparam logic [2:0] REG_MASK = 3'd5;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_MERGE = 2'd2;

	// one command from front to back
	typedef struct packed {
		logic [1:0]    op;
		logic [AW-1:0] addr0;
		logic          en0;
		logic [AW-1:0] addr1;
		logic          en1;
		logic [15:0]   bits;
		logic [15:0]   clr;
		logic [7:0]    wdata;
	} cmd_t;
endpackage
`default_nettype wire

### design/masked_sprite_blit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sprite byte: accepted in idle, then a read and then a write on the single
// RAM port per framebuffer page touched (up to two); no new word is taken
// until done. Read: RAM read in the accept cycle, word registered from RD0
// once no earlier result waits on m_tready. Write: done in the accept cycle.
// Reset (arst_n low) clears counters and result valid, sets config to 8x8 at
// 0,0 with mirror and mask off; RAM content is undefined until written.
module masked_sprite_blit import msb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: bitmap_byte[7:0], mask_byte[15:8], fb_address[25:16], write_data[33:26]
	input  wire logic [39:0] s_tdata,
	// tuser: kind[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: read_data[7:0]
	output logic [7:0]       m_tdata
);
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	msb_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(s_tvalid), .in_ready(s_tready),
		.kind(s_tuser), .bitmap_byte(s_tdata[7:0]), .mask_byte(s_tdata[15:8]),
		.fb_address(s_tdata[25:16]), .write_data(s_tdata[33:26]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	msb_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata));
endmodule
`default_nettype wire

### design/msb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module msb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### design/msb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module msb_front import msb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  bitmap_byte,
	input  wire logic [7:0]  mask_byte,
	input  wire logic [AW-1:0] fb_address,
	input  wire logic [7:0]  write_data,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);
	logic signed [7:0] x_q, y_q;
	logic [7:0] w_q, h_q, col_q;
	logic [5:0] page_q;
	logic mir_q, msk_q;

	logic signed [10:0] sx, lo, hi, xw, yh, mx, r0, r1;
	logic [5:0] pages;
	logic [2:0] yoff;
	logic off, vis, ok0, ok1;
	logic [15:0] bits, clr;

	assign in_ready = cmd_ready;
	assign cmd_valid = in_valid && (kind != KIND_NONE);

	always_comb begin
		pages = 6'(({1'b0, h_q} + 9'd7) >> 3);
		xw = 11'(x_q) + 11'({3'b0, w_q});
		yh = 11'(y_q) + 11'({3'b0, h_q});
		off = xw < 0 || x_q > 8'sd127 || yh < 0 || 11'(y_q) > 11'(SCREEN_HEIGHT - 1);
		sx = 11'(x_q) + 11'({3'b0, col_q});
		vis = !off && sx >= 0 && sx <= 11'(SCREEN_WIDTH - 1);
		lo = x_q < 0 ? 11'sd0 : 11'(x_q);
		hi = xw - 11'sd1;
		if (hi > 11'(SCREEN_WIDTH - 1)) hi = 11'(SCREEN_WIDTH - 1);
		mx = mir_q ? lo + hi - sx : sx;
		yoff = y_q[2:0];
		r0 = 11'(y_q >>> 3) + 11'({5'b0, page_q});
		r1 = r0 + 11'sd1;
		ok0 = vis && r0 >= 0 && r0 < 11'(SCREEN_PAGES);
		ok1 = vis && yoff != 3'd0 && r1 >= 0 && r1 < 11'(SCREEN_PAGES);
		bits = {8'b0, bitmap_byte} << yoff;
		clr = msk_q ? ({8'b0, mask_byte} << yoff) : 16'b0;
		cmd.bits = bits;
		cmd.clr = clr;
		cmd.wdata = write_data;
		cmd.addr0 = fb_address;
		cmd.addr1 = fb_address;
		cmd.en0 = 1'b1;
		cmd.en1 = 1'b0;
		cmd.op = OP_READ;
		case (kind)
			KIND_READ: cmd.en0 = {1'b0, fb_address} < (AW+1)'(FB_BYTES);
			KIND_WRITE: begin
				cmd.op = OP_WRITE;
				cmd.en0 = {1'b0, fb_address} < (AW+1)'(FB_BYTES);
			end
			default: begin
				cmd.op = OP_MERGE;
				cmd.addr0 = AW'(r0 * 11'(SCREEN_WIDTH) + mx);
				cmd.addr1 = AW'(r1 * 11'(SCREEN_WIDTH) + mx);
				cmd.en0 = ok0 && w_q != 0 && pages != 0;
				cmd.en1 = ok1 && w_q != 0 && pages != 0;
			end
		endcase
	end

	// hold config, advance sprite counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; w_q <= 8'd8; h_q <= 8'd8;
			mir_q <= 1'b0; msk_q <= 1'b0; col_q <= '0; page_q <= '0;
		end else if (cfg_we && cfg_index <= REG_MASK) begin
			case (cfg_index)
				REG_X: x_q <= cfg_data;
				REG_Y: y_q <= cfg_data;
				REG_W: w_q <= cfg_data;
				REG_H: h_q <= cfg_data;
				REG_MIRROR: mir_q <= cfg_data[0];
				default: msk_q <= cfg_data[0];
			endcase
			col_q <= '0;
			page_q <= '0;
		end else if (in_valid && in_ready && kind == KIND_SPRITE &&
				w_q != 0 && pages != 0) begin
			if (col_q + 8'd1 >= w_q) begin
				col_q <= '0;
				page_q <= (page_q + 6'd1 >= pages) ? 6'd0 : page_q + 6'd1;
			end else col_q <= col_q + 8'd1;
		end
	end
endmodule
`default_nettype wire

### design/msb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module msb_back import msb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cmd_valid,
	output logic        cmd_ready,
	input  wire cmd_t   cmd,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [7:0]  out_data
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_RD0 = 5'b00010, ST_WR0 = 5'b00100,
		ST_RD1 = 5'b01000, ST_WR1 = 5'b10000
	} st_t;
	st_t st_q;
	cmd_t c_q;
	logic [1:0] cnt_q;
	logic we;
	logic [AW-1:0] addr;
	logic [7:0] wd, rd;
	logic rd_done;

	msb_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wd), .rdata(rd));

	assign cmd_ready = st_q == ST_IDLE;
	// a read finishes once the result register is free or being emptied
	assign rd_done = st_q == ST_RD0 && cnt_q == 2'd1 && (!out_valid || out_ready);

	// drive the single port from the state
	always_comb begin
		we = 1'b0;
		addr = c_q.addr0;
		wd = (rd & ~c_q.clr[7:0]) | c_q.bits[7:0];
		case (st_q)
			ST_RD0: addr = c_q.addr0;
			ST_WR0: we = 1'b1;
			ST_RD1: addr = c_q.addr1;
			ST_WR1: begin
				addr = c_q.addr1;
				we = 1'b1;
				wd = (rd & ~c_q.clr[15:8]) | c_q.bits[15:8];
			end
			default: begin
				addr = cmd.addr0;
				we = cmd_valid && cmd_ready && cmd.op == OP_WRITE && cmd.en0;
				wd = cmd.wdata;
			end
		endcase
	end

	always_ff @(posedge clk) if (cmd_valid && cmd_ready) c_q <= cmd;

	// sequence read-modify-write and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_valid <= 1'b0; cnt_q <= '0; out_data <= '0;
		end else begin
			if (rd_done) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: if (cmd_valid && cmd_ready) begin
					if (cmd.op == OP_READ) begin
						st_q <= ST_RD0;
						cnt_q <= 2'd1;
					end else if (cmd.op == OP_MERGE) begin
						if (cmd.en0) st_q <= ST_RD0;
						else if (cmd.en1) st_q <= ST_RD1;
						cnt_q <= 2'd0;
					end
				end
				ST_RD0: if (cnt_q == 2'd1) begin
					// hold the read until the result register frees up
					if (rd_done) begin
						out_data <= c_q.en0 ? rd : 8'd0;
						st_q <= ST_IDLE;
					end
				end else st_q <= ST_WR0;
				ST_WR0: st_q <= c_q.en1 ? ST_RD1 : ST_IDLE;
				ST_RD1: st_q <= ST_WR1;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/msb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module msb_checker import msb_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [1:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown(m_tdata)) else $error("unknown word");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_READ |=> ##1 m_tvalid) else $error("no read");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_WRITE && !m_tvalid |=> !m_tvalid)
		else $error("extra");
endmodule
bind masked_sprite_blit msb_checker u_chk (.*);
`default_nettype wire
